FILE: rtl/core/small_int_alu_with_fallback_assert.svh
// assertion macros for the small-int alu
// used by the top level only
`ifndef SMALL_INT_ALU_WITH_FALLBACK_ASSERT_SVH
`define SMALL_INT_ALU_WITH_FALLBACK_ASSERT_SVH

// a property that must hold on every edge out of reset
`define SIA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// an implication whose consequent is checked in the cycle after the antecedent
`define SIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sia_pkg.sv
// shared types, codes and constants for the small-int alu
// no dependencies
`default_nettype none
package sia_pkg;
  localparam int FIELD_BITS = 62;
  localparam int SMALL_INT_BITS_DEF = 62;
  localparam int MAX_SHIFT = 63;
  localparam int STAGES = 64;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_FDIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_LSH = 4'd5;
  localparam logic [3:0] OP_RSH = 4'd6;
  localparam logic [3:0] OP_AND = 4'd7;
  localparam logic [3:0] OP_OR = 4'd8;
  localparam logic [3:0] OP_XOR = 4'd9;
  localparam logic [3:0] OP_NEG = 4'd10;
  localparam logic [3:0] OP_POS = 4'd11;
  localparam logic [3:0] OP_INV = 4'd12;

  // token handed from cell to cell; one bit of quotient / product per cell
  typedef struct packed {
    logic        vld;
    logic [3:0]  act;
    logic        ok;
    logic        neg;     // result sign for mul / div
    logic [63:0] a;       // multiplicand or dividend magnitude (shifting)
    logic [63:0] b;       // multiplier or divisor magnitude
    logic [127:0] acc;    // mul: product, div: remainder
    logic [63:0] q;       // quotient bits
    logic [63:0] fast;    // result of ops computed in the entry decode
    logic        bneg;    // divisor negative
  } tok_t;
endpackage
`default_nettype wire

FILE: rtl/core/sia_cell.sv
// one cell of the mul/div chain: one multiplier bit or one quotient bit
// depends on sia_pkg
`default_nettype none
module sia_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire sia_pkg::tok_t din,
  output sia_pkg::tok_t      dout
);
  sia_pkg::tok_t nx;
  logic [64:0] trial;
  logic [127:0] rem;

  always_comb begin
    nx = din;
    rem = {din.acc[126:0], din.a[63]};
    trial = {1'b0, rem[63:0]} - {1'b0, din.b};
    if (din.act == sia_pkg::OP_MUL) begin
      if (din.b[IDX]) nx.acc = din.acc + ({64'd0, din.a} << IDX);
    end else begin
      // restoring division, dividend bit shifted out of a
      nx.a = {din.a[62:0], 1'b0};
      nx.acc = rem;
      nx.q = {din.q[62:0], 1'b0};
      if (rem[127:64] == 64'd0 && !trial[64]) begin
        nx.acc = {64'd0, trial[63:0]};
        nx.q[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= nx;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/small_int_alu_with_fallback.sv
// top level of the small-int alu: entry decode, chain of cells, result check
// depends on sia_pkg, sia_cell, small_int_alu_with_fallback_assert.svh
//
//  channel | dir | tdata (low bit up)                         | tuser
//  s_axis  | in  | action[3:0] lhs_value[65:4] rhs_value[127:66] | lhs_is_small rhs_is_small
//  m_axis  | out | result_value[61:0]                          | handled
//
// one beat per cycle while the output register is empty or taken; a beat passes the
// entry register, the 64-cell mul/div chain and the exit register. the whole chain
// advances together and holds when the output register is full and not taken.
// rst clears valid bits.
`default_nettype none
module small_int_alu_with_fallback #(
  parameter int SMALL_INT_BITS = sia_pkg::SMALL_INT_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // action, lhs_value, rhs_value
  input  wire logic [1:0]   s_axis_tuser,  // lhs_is_small, rhs_is_small
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // result_value, zero pad
  output logic              m_axis_tuser   // handled
);
  localparam int W = (SMALL_INT_BITS < sia_pkg::FIELD_BITS) ? SMALL_INT_BITS
                                                             : sia_pkg::FIELD_BITS;
  localparam int N = sia_pkg::STAGES;
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [3:0] act;
  logic signed [63:0] a, b;
  assign act = s_axis_tdata[3:0];
  assign a = {{2{s_axis_tdata[65]}}, s_axis_tdata[65:4]};
  assign b = {{2{s_axis_tdata[127]}}, s_axis_tdata[127:66]};

  // entry decode: operand checks and all actions that do not use the cell chain
  sia_pkg::tok_t t0;
  logic a_ok, b_ok;
  logic [63:0] ua, ub, lim;
  logic signed [63:0] rsh;
  always_comb begin
    a_ok = s_axis_tuser[0] && a >= SMIN && a <= SMAX;
    b_ok = s_axis_tuser[1] && b >= SMIN && b <= SMAX;
    ua = a[63] ? 64'(-a) : 64'(a);
    ub = b[63] ? 64'(-b) : 64'(b);
    t0 = '0;
    t0.vld = s_axis_tvalid;
    t0.act = act;
    t0.ok = (act >= sia_pkg::OP_NEG) ? a_ok : (a_ok && b_ok);
    t0.a = ua;
    t0.b = ub;
    t0.bneg = b[63];
    t0.neg = a[63] ^ b[63];
    lim = 64'(SMAX);
    rsh = a >>> b[5:0];
    case (act)
      sia_pkg::OP_ADD: t0.fast = 64'(a + b);
      sia_pkg::OP_SUB: t0.fast = 64'(a - b);
      sia_pkg::OP_MUL: t0.fast = '0;
      sia_pkg::OP_FDIV, sia_pkg::OP_MOD: begin
        if (b == 64'sd0) t0.ok = 1'b0;
        t0.a = ua;
      end
      sia_pkg::OP_LSH: begin
        if (b < 0 || b >= 64'(sia_pkg::MAX_SHIFT)) t0.ok = 1'b0;
        else begin
          // magnitude must fit after shift, negative side one larger
          if (ua > ((a[63] ? lim + 64'd1 : lim) >> b[5:0])) t0.ok = 1'b0;
          t0.fast = 64'(a <<< b[5:0]);
        end
      end
      sia_pkg::OP_RSH: begin
        if (b < 0 || b >= 64'(sia_pkg::MAX_SHIFT)) t0.ok = 1'b0;
        t0.fast = 64'(rsh);
      end
      sia_pkg::OP_AND: t0.fast = 64'(a & b);
      sia_pkg::OP_OR:  t0.fast = 64'(a | b);
      sia_pkg::OP_XOR: t0.fast = 64'(a ^ b);
      sia_pkg::OP_NEG: t0.fast = 64'(-a);
      sia_pkg::OP_POS: t0.fast = 64'(a);
      sia_pkg::OP_INV: t0.fast = 64'(~a);
      default: t0.ok = 1'b0;
    endcase
  end

  sia_pkg::tok_t chain [N+1];
  always_ff @(posedge clk) begin
    if (rst) chain[0].vld <= 1'b0;
    else if (en) chain[0] <= t0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    // mul cells walk bits low to high; div cells consume dividend high first
    sia_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst(rst), .en(en), .din(chain[i]), .dout(chain[i+1])
    );
  end

  // exit: sign fix, floor correction, range check
  sia_pkg::tok_t tl;
  logic signed [63:0] res, q, m;
  logic ok;
  assign tl = chain[N];
  always_comb begin
    ok = tl.ok;
    q = tl.neg ? 64'(-tl.q) : 64'(tl.q);
    // truncated remainder takes dividend sign (neg xor bneg gives it)
    m = (tl.neg ^ tl.bneg) ? 64'(-tl.acc[63:0]) : 64'(tl.acc[63:0]);
    if (m != 0 && (m[63] != tl.bneg)) begin
      q = q - 64'sd1;
      m = m + (tl.bneg ? 64'(-tl.b) : 64'(tl.b));
    end
    case (tl.act)
      sia_pkg::OP_MUL: begin
        if (tl.acc[127:64] != 64'd0 || tl.acc[63]) ok = 1'b0;
        res = tl.neg ? 64'(-tl.acc[63:0]) : 64'(tl.acc[63:0]);
      end
      sia_pkg::OP_FDIV: res = q;
      sia_pkg::OP_MOD:  res = m;
      default:          res = 64'(tl.fast);
    endcase
    if (res < SMIN || res > SMAX) ok = 1'b0;
    if (!ok) res = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= tl.vld;
      m_axis_tdata <= {2'b00, res[61:0]};
      m_axis_tuser <= ok;
    end
  end

`include "small_int_alu_with_fallback_assert.svh"
  `SIA_ASSERT(a_pad_zero, !m_axis_tvalid || m_axis_tdata[63:62] == 2'b00, "pad bits set")
  `SIA_ASSERT(a_unhandled_zero, !(m_axis_tvalid && !m_axis_tuser) || m_axis_tdata == '0, "unhandled")
  `SIA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output not held")
endmodule
`default_nettype wire
